@@ hdl/assert_macros.svh @@
// assertion macros shared by the bucketed hash set rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge outside reset
`define BHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bhs assertion failed");

// next-cycle implication, checked on the rising edge outside reset
`define BHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bhs assertion failed");

`endif

@@ hdl/bhs_pkg.sv @@
// shared types, sizes and codes of the bucketed hash set
package bhs_pkg;

    // table geometry
    localparam int NUM_BUCKETS  = 10;
    localparam int BUCKET_DEPTH = 8;

    // field widths
    localparam int REQ_W   = 2;
    localparam int VALUE_W = 31;
    localparam int STAT_W  = 2;
    localparam int BKT_W   = 4;
    localparam int FILL_W  = 4;

    // derived sizes
    localparam int BSEL_W  = $clog2(NUM_BUCKETS);
    localparam int SLOTS   = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

    // request beat
    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [VALUE_W-1:0] value;
    } t_req;

    // result beat
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BKT_W-1:0]  bucket_index;
    } t_rsp;

endpackage

@@ hdl/bhs_mod.sv @@
// iterative residue unit: value modulo the bucket count, one 4-bit digit per cycle
module bhs_mod
    import bhs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_done,
    output logic [BSEL_W-1:0]  o_rem
);

    localparam int DIG_N  = (VALUE_W + 3) / 4;
    localparam int PAD_W  = DIG_N * 4;
    localparam int CNT_W  = (DIG_N > 1) ? $clog2(DIG_N) : 1;
    localparam int TMP_W  = BSEL_W + 4;
    localparam logic [TMP_W-1:0] NB_W = TMP_W'(NUM_BUCKETS);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt,  n_cnt;
    logic [PAD_W-1:0]   r_shift, n_shift;
    logic [BSEL_W-1:0]  r_rem,  n_rem;
    logic [TMP_W-1:0]   step_tmp;

    // one digit step: append the next digit, then reduce by conditional subtracts
    always_comb begin
        step_tmp = {r_rem, r_shift[PAD_W-1 -: 4]};
        for (int k = 3; k >= 0; k--) begin
            if (step_tmp >= (NB_W << k)) begin
                step_tmp = step_tmp - (NB_W << k);
            end
        end
    end

    // sequencer
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_rem   = r_rem;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = CNT_W'(DIG_N - 1);
            n_shift = PAD_W'(i_value);
            n_rem   = '0;
        end else if (r_busy) begin
            n_rem   = step_tmp[BSEL_W-1:0];
            n_shift = r_shift << 4;
            n_cnt   = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_shift <= n_shift;
        r_rem   <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ hdl/bucketed_hash_set_top.sv @@
// bucketed hash set: top level with sequencer, slot memory and fill counts
//
// Each request is taken on a clock edge with i_start high and o_busy low, and
// exactly one result beat follows, shown for one cycle with o_done high; the
// receiver cannot hold it off. The bucket is found by the residue unit, one
// 4-bit digit of the value per cycle, then handed to a decision state that
// finishes an insert or unused code. Delete and search read the bucket
// through the slot memory's single read port, with one read state and one
// compare state per entry compared, and delete then moves each later entry
// down one place with a read state and a write state. Slots hold no reset
// value: only entries below a bucket's fill count are ever read.
`include "assert_macros.svh"

module bucketed_hash_set_top
    import bhs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);

    // sequencer states
    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE   = 3'd0;
    localparam logic [STATE_W-1:0] S_MOD    = 3'd1;
    localparam logic [STATE_W-1:0] S_DECIDE = 3'd2;
    localparam logic [STATE_W-1:0] S_SRD    = 3'd3;
    localparam logic [STATE_W-1:0] S_SCMP   = 3'd4;
    localparam logic [STATE_W-1:0] S_MRD    = 3'd5;
    localparam logic [STATE_W-1:0] S_MWR    = 3'd6;

    logic [STATE_W-1:0] r_state, n_state;
    t_req               r_req,   n_req;
    logic [BSEL_W-1:0]  r_bkt,   n_bkt;
    logic [FILL_W-1:0]  r_idx,   n_idx;
    logic               r_done,  n_done;
    t_rsp               r_rsp,   n_rsp;
    logic [FILL_W-1:0]  r_fill [NUM_BUCKETS];

    logic [VALUE_W-1:0] r_mem [SLOTS];
    logic [VALUE_W-1:0] r_rdata;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [VALUE_W-1:0] wr_data;

    logic               accept;
    logic               mod_done;
    logic [BSEL_W-1:0]  mod_rem;
    logic               fill_inc, fill_dec;
    logic [ADDR_W-1:0]  base;
    logic [FILL_W-1:0]  fill_cur;
    logic [FILL_W:0]    fill_ext, idx_p1, idx_p2;
    logic [BSEL_W+3:0]  bkt_ext;

    assign accept = i_start && (r_state == S_IDLE);

    // residue unit picks the bucket
    bhs_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_value (i_req.value),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // bucket addressing and index arithmetic
    assign base     = ADDR_W'(r_bkt) * ADDR_W'(BUCKET_DEPTH);
    assign fill_cur = r_fill[r_bkt];
    assign fill_ext = {1'b0, fill_cur};
    assign idx_p1   = {1'b0, r_idx} + (FILL_W+1)'(1);
    assign idx_p2   = {1'b0, r_idx} + (FILL_W+1)'(2);
    assign bkt_ext  = (BSEL_W+4)'(r_bkt);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_bkt    = r_bkt;
        n_idx    = r_idx;
        n_done   = 1'b0;
        n_rsp    = r_rsp;
        rd_addr  = base + ADDR_W'(r_idx);
        wr_en    = 1'b0;
        wr_addr  = base + ADDR_W'(r_idx);
        wr_data  = r_rdata;
        fill_inc = 1'b0;
        fill_dec = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_bkt   = mod_rem;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_idx                = '0;
                n_rsp.bucket_index   = bkt_ext[BKT_W-1:0];
                n_rsp.status         = ST_MISSING;
                case (r_req.req_type)
                    REQ_INSERT: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                        if (fill_cur < FILL_W'(BUCKET_DEPTH)) begin
                            wr_en        = 1'b1;
                            wr_addr      = base + ADDR_W'(fill_cur);
                            wr_data      = r_req.value;
                            fill_inc     = 1'b1;
                            n_rsp.status = ST_OK;
                        end else begin
                            n_rsp.status = ST_FULL;
                        end
                    end
                    REQ_DELETE, REQ_SEARCH: begin
                        if (fill_cur == '0) begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_SRD;
                        end
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SRD: begin
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (r_rdata == r_req.value) begin
                    if (r_req.req_type == REQ_SEARCH) begin
                        n_rsp.status = ST_OK;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end else if (idx_p1 < fill_ext) begin
                        n_state = S_MRD;
                    end else begin
                        fill_dec     = 1'b1;
                        n_rsp.status = ST_OK;
                        n_done       = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (idx_p1 < fill_ext) begin
                    n_idx   = idx_p1[FILL_W-1:0];
                    n_state = S_SRD;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MRD: begin
                rd_addr = base + ADDR_W'(idx_p1);
                n_state = S_MWR;
            end
            S_MWR: begin
                // move the later entry down one slot
                wr_en = 1'b1;
                n_idx = idx_p1[FILL_W-1:0];
                if (idx_p2 < fill_ext) begin
                    n_state = S_MRD;
                end else begin
                    fill_dec     = 1'b1;
                    n_rsp.status = ST_OK;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers and fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                r_fill[b] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (fill_inc) begin
                r_fill[r_bkt] <= fill_cur + 1'b1;
            end else if (fill_dec) begin
                r_fill[r_bkt] <= fill_cur - 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_bkt <= n_bkt;
        r_idx <= n_idx;
        r_rsp <= n_rsp;
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // result strobe lasts one cycle
    `BHS_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)
    // a taken request keeps the block busy next cycle
    `BHS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, o_busy)
    // bucket fill never exceeds its depth
    `BHS_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, r_state == S_DECIDE,
        fill_cur <= FILL_W'(BUCKET_DEPTH))
    // full status comes only from an insert
    `BHS_ASSERT_IMP(a_full_insert, i_clk, i_rst_n, r_done && (r_rsp.status == ST_FULL),
        r_req.req_type == REQ_INSERT)

endmodule

@@ bench/bhs_checker.sv @@
// scoreboard for the bucketed hash set: mirrors the table and checks every result beat
`timescale 1ns / 1ps

module bhs_checker
    import bhs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_busy,
    input  t_req i_req,
    input  logic i_done,
    input  t_rsp i_rsp,
    output int   o_errors,
    output int   o_pending
);

    // mirror of the table contents and per-bucket fill counts
    logic [VALUE_W-1:0] slot_mirror [NUM_BUCKETS][BUCKET_DEPTH];
    int                 fill_mirror [NUM_BUCKETS];

    // results owed by the block, oldest first
    t_rsp rsp_due [$];
    int   err_cnt = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        foreach (fill_mirror[b]) fill_mirror[b] = 0;
    end

    // position of the first match in a bucket, or -1
    function automatic int find_key(int b, logic [VALUE_W-1:0] key);
        for (int i = 0; i < fill_mirror[b]; i++) begin
            if (slot_mirror[b][i] == key) return i;
        end
        return -1;
    endfunction

    // apply one request to the mirror and return the result it must produce
    function automatic t_rsp hash_set_apply(t_req r);
        int   b;
        int   pos;
        t_rsp res;
        b                = int'(r.value % NUM_BUCKETS);
        res.bucket_index = BKT_W'(b);
        res.status       = ST_MISSING;
        case (r.req_type)
            REQ_INSERT: begin
                if (fill_mirror[b] < BUCKET_DEPTH) begin
                    slot_mirror[b][fill_mirror[b]] = r.value;
                    fill_mirror[b]++;
                    res.status = ST_OK;
                end else begin
                    res.status = ST_FULL;
                end
            end
            REQ_DELETE: begin
                pos = find_key(b, r.value);
                if (pos >= 0) begin
                    // close the gap so the later entries keep their order
                    for (int i = pos; i + 1 < fill_mirror[b]; i++)
                        slot_mirror[b][i] = slot_mirror[b][i + 1];
                    fill_mirror[b]--;
                    res.status = ST_OK;
                end
            end
            REQ_SEARCH: begin
                if (find_key(b, r.value) >= 0) res.status = ST_OK;
            end
            default: ;
        endcase
        return res;
    endfunction

    // compare result beats, then record newly accepted request beats
    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            foreach (fill_mirror[b]) fill_mirror[b] = 0;
            rsp_due.delete();
        end else begin
            if (i_done === 1'b1) begin
                if (rsp_due.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, i_rsp);
                end else begin
                    want = rsp_due.pop_front();
                    if (i_rsp.status !== want.status) begin
                        err_cnt++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, i_rsp.status);
                    end
                    if (i_rsp.bucket_index !== want.bucket_index) begin
                        err_cnt++;
                        $display("%0t: bucket_index mismatch, expected %0d, actual %0d",
                                 $time, want.bucket_index, i_rsp.bucket_index);
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) rsp_due.push_back(hash_set_apply(i_req));
        end
        o_errors  <= err_cnt;
        o_pending <= rsp_due.size();
    end

endmodule

@@ bench/tb.sv @@
// testbench top for the bucketed hash set: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb
    import bhs_pkg::*;
();

    // request code the block does not define
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int               POOL_SIZE  = 48;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    t_req req   = '0;
    logic busy;
    logic done;
    t_rsp rsp;
    int   errors;
    int   pending;

    // keys reused often so that buckets fill up and deletes hit
    logic [VALUE_W-1:0] key_pool [POOL_SIZE];

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    bucketed_hash_set_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_start (start),
        .i_req   (req),
        .o_busy  (busy),
        .o_done  (done),
        .o_rsp   (rsp)
    );

    bhs_checker u_checker (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_req     (req),
        .i_done    (done),
        .i_rsp     (rsp),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // present one request beat and hold it until the block takes it
    task automatic send_req(input logic [REQ_W-1:0] op, input logic [VALUE_W-1:0] v);
        start <= 1'b1;
        req   <= {op, v};
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // mostly pooled keys, some fully random, some small
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 85) return VALUE_W'($urandom);
        return VALUE_W'($urandom_range(0, 99));
    endfunction

    // operation mix biased toward insert by ins_pct
    function automatic logic [REQ_W-1:0] pick_op(int ins_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return REQ_UNUSED;
        if (r < 4 + ins_pct) return REQ_INSERT;
        if (r < 4 + ins_pct + (96 - ins_pct) / 2) return REQ_DELETE;
        return REQ_SEARCH;
    endfunction

    initial begin
        int left;
        int burst;
        int gap;
        int ins_pct;

        foreach (key_pool[i]) begin
            if (i < 24)      key_pool[i] = VALUE_W'($urandom_range(0, 199));
            else if (i < 32) key_pool[i] = VALUE_MAX - VALUE_W'($urandom_range(0, 40));
            else             key_pool[i] = VALUE_W'($urandom);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, lookups of present and missing keys, missing delete
        send_req(REQ_INSERT, '0);
        send_req(REQ_INSERT, VALUE_MAX);
        send_req(REQ_SEARCH, '0);
        send_req(REQ_SEARCH, VALUE_MAX);
        send_req(REQ_SEARCH, 31'd10);
        send_req(REQ_DELETE, 31'd20);
        // directed: fill bucket 3 with a duplicate, then overflow it
        send_req(REQ_INSERT, 31'd3);
        send_req(REQ_INSERT, 31'd3);
        send_req(REQ_INSERT, 31'd13);
        send_req(REQ_INSERT, 31'd23);
        send_req(REQ_INSERT, 31'd33);
        send_req(REQ_INSERT, 31'd43);
        send_req(REQ_INSERT, 31'd53);
        send_req(REQ_INSERT, 31'd63);
        send_req(REQ_INSERT, 31'd73);
        send_req(REQ_SEARCH, 31'd63);
        // directed: head delete keeps the duplicate, middle delete, refill
        send_req(REQ_DELETE, 31'd3);
        send_req(REQ_SEARCH, 31'd3);
        send_req(REQ_DELETE, 31'd33);
        send_req(REQ_SEARCH, 31'd33);
        send_req(REQ_INSERT, 31'd73);
        // directed: unused code, even on a present key, then delete the extremes
        send_req(REQ_UNUSED, VALUE_MAX);
        send_req(REQ_UNUSED, 31'd3);
        send_req(REQ_DELETE, '0);
        send_req(REQ_DELETE, VALUE_MAX);
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);

        // random: phases alternate between filling and draining the table
        for (int ph = 0; ph < 7; ph++) begin
            ins_pct = (ph % 2 == 0) ? 60 : 25;
            left    = (ph == 6) ? 125 : 150;
            while (left > 0) begin
                burst = $urandom_range(1, 24);
                if (burst > left) burst = left;
                for (int k = 0; k < burst; k++) send_req(pick_op(ins_pct), pick_value());
                left -= burst;
                // phase 3 runs back to back; otherwise idle now and then
                gap = (ph == 3 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        start <= 1'b0;

        // drain outstanding results, then let the block settle
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        // every owed result must have arrived and matched
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
